@@ hdl/nel_pkg.sv @@
// ----------------------------------------------------------------------------
// nel_pkg: shared types and constants for the nearest exon lookup
// Operation and status codes, default sizes and the back-end sequencer states.
// ----------------------------------------------------------------------------
package nel_pkg;

   localparam int DefTableDepth = 65536;
   localparam int DefNumChrom   = 24;
   localparam int DefPosWidth   = 28;
   localparam int ChromWidth    = 5;
   localparam int TagWidth      = 16;
   localparam int RadiusWidth   = 4;
   localparam logic [RadiusWidth-1:0] RadiusReset = 4'd5;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_QUERY = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ORDER    = 2'd1,
      ST_FULL     = 2'd2,
      ST_BADCHROM = 2'd3
   } status_type;

   // Back-end sequencer states.
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SEARCH_RD,
      BK_SEARCH_CMP,
      BK_SCAN_RD,
      BK_SCAN_CMP,
      BK_DONE
   } back_state_type;

endpackage

@@ hdl/nel_ram.sv @@
// ----------------------------------------------------------------------------
// nel_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module nel_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ hdl/nel_front.sv @@
// ----------------------------------------------------------------------------
// nel_front: table bookkeeping and item classification
// Checks loads, keeps per-chromosome run bounds, and hands each item to the
// back end as a resolved command with its run bounds attached.
// ----------------------------------------------------------------------------
module nel_front #(
   parameter int TABLE_DEPTH     = 65536,
   parameter int NUM_CHROMOSOMES = 24,
   parameter int POS_WIDTH       = 28,
   localparam int AW = $clog2(TABLE_DEPTH),
   localparam int CW = AW + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_stall,
   input  logic [1:0]                    in_op,
   input  logic [nel_pkg::ChromWidth-1:0] in_chrom,
   input  logic [POS_WIDTH-1:0]          in_pos,
   input  logic [POS_WIDTH-1:0]          in_end,
   input  logic [nel_pkg::TagWidth-1:0]  in_tag,
   // High when the queue is empty and the back end is idle.
   input  logic                          drained,
   // Table write port.
   output logic                          wr_en,
   output logic [AW-1:0]                 wr_addr,
   output logic [2*POS_WIDTH+nel_pkg::TagWidth-1:0] wr_data,
   // Command toward the back end.
   output logic                          cmd_valid,
   input  logic                          cmd_stall,
   output logic                          cmd_query,
   output logic [1:0]                    cmd_status,
   output logic [POS_WIDTH-1:0]          cmd_pos,
   output logic [AW-1:0]                 cmd_first,
   output logic [CW-1:0]                 cmd_count
);
   import nel_pkg::*;

   logic [AW-1:0]         first_ff [NUM_CHROMOSOMES];
   logic [CW-1:0]         count_ff [NUM_CHROMOSOMES];
   logic [CW-1:0]         total_ff;
   logic [ChromWidth-1:0] last_chrom_ff;
   logic [POS_WIDTH-1:0]  last_start_ff;
   logic                  clear_pend_ff;

   logic                  take;
   logic                  bad;
   logic [ChromWidth-1:0] cidx;
   logic                  load_ok;
   logic [1:0]            status_in;
   logic                  load_hold;

   // After a clear, a load would overwrite entries that queries still in
   // flight may read, so loads wait until the back end has drained.
   assign load_hold = clear_pend_ff && (op_type'(in_op) == OP_LOAD);
   assign in_stall  = cmd_stall || load_hold;
   assign take      = in_valid && !in_stall;
   assign bad       = (in_chrom == '0) || (32'(in_chrom) > NUM_CHROMOSOMES);
   assign cidx      = bad ? '0 : in_chrom - ChromWidth'(1);

   // Classify the beat.
   always_comb begin
      status_in = ST_OK;
      load_ok   = 1'b0;
      case (op_type'(in_op))
         OP_LOAD: begin
            if (bad) begin
               status_in = ST_BADCHROM;
            end else if (in_chrom < last_chrom_ff ||
                         (in_chrom == last_chrom_ff && in_pos < last_start_ff)) begin
               status_in = ST_ORDER;
            end else if (32'(total_ff) >= TABLE_DEPTH) begin
               status_in = ST_FULL;
            end else begin
               load_ok = 1'b1;
            end
         end
         OP_QUERY: begin
            if (bad) begin
               status_in = ST_BADCHROM;
            end
         end
         default: status_in = ST_OK;
      endcase
   end

   assign wr_en   = take && load_ok;
   assign wr_addr = total_ff[AW-1:0];
   assign wr_data = {in_pos, in_end, in_tag};

   // Pending-clear flag, set by a clear and dropped once all work ahead is done.
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_pend_ff <= 1'b0;
      end else if (take && op_type'(in_op) == OP_CLEAR) begin
         clear_pend_ff <= 1'b1;
      end else if (drained) begin
         clear_pend_ff <= 1'b0;
      end
   end

   // Bookkeeping registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHROMOSOMES; i++) begin
            first_ff[i] <= '0;
            count_ff[i] <= '0;
         end
         total_ff      <= '0;
         last_chrom_ff <= '0;
         last_start_ff <= '0;
      end else if (take) begin
         if (op_type'(in_op) == OP_CLEAR) begin
            for (int i = 0; i < NUM_CHROMOSOMES; i++) begin
               first_ff[i] <= '0;
               count_ff[i] <= '0;
            end
            total_ff      <= '0;
            last_chrom_ff <= '0;
            last_start_ff <= '0;
         end else if (load_ok) begin
            if (count_ff[cidx] == '0) begin
               first_ff[cidx] <= total_ff[AW-1:0];
            end
            count_ff[cidx] <= count_ff[cidx] + CW'(1);
            total_ff       <= total_ff + CW'(1);
            last_chrom_ff  <= in_chrom;
            last_start_ff  <= in_pos;
         end
      end
   end

   // Command to the queue; loads are complete here and need only a status.
   assign cmd_valid  = take;
   assign cmd_query  = (op_type'(in_op) == OP_QUERY) && !bad;
   assign cmd_status = status_in;
   assign cmd_pos    = in_pos;
   assign cmd_first  = first_ff[cidx];
   assign cmd_count  = count_ff[cidx];
endmodule

@@ hdl/nel_back.sv @@
// ----------------------------------------------------------------------------
// nel_back: query sequencer
// Binary search for the landing index, then a window scan for the nearest
// entry, each table read followed by a compare state; non-query commands pass straight out.
// ----------------------------------------------------------------------------
module nel_back #(
   parameter int TABLE_DEPTH = 65536,
   parameter int POS_WIDTH   = 28,
   localparam int AW = $clog2(TABLE_DEPTH),
   localparam int CW = AW + 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [nel_pkg::RadiusWidth-1:0] radius,
   input  logic                         cmd_valid,
   output logic                         cmd_pop,
   input  logic                         cmd_query,
   input  logic [1:0]                   cmd_status,
   input  logic [POS_WIDTH-1:0]         cmd_pos,
   input  logic [AW-1:0]                cmd_first,
   input  logic [CW-1:0]                cmd_count,
   output logic                         idle,
   output logic [AW-1:0]                rd_addr,
   input  logic [2*POS_WIDTH+nel_pkg::TagWidth-1:0] rd_data,
   output logic                         out_valid,
   input  logic                         out_stall,
   output logic [1:0]                   out_status,
   output logic                         out_found,
   output logic [nel_pkg::TagWidth-1:0] out_tag,
   output logic [POS_WIDTH-1:0]         out_start,
   output logic [POS_WIDTH-1:0]         out_dist
);
   import nel_pkg::*;

   // Signed window index needs room for count plus radius.
   localparam int JW = CW + 2;

   back_state_type state_ff, state_in;
   logic [CW-1:0]        lo_ff, lo_in, hi_ff, hi_in;
   logic [JW-1:0]        j_ff, j_in, jend_ff, jend_in;
   logic [POS_WIDTH-1:0] pos_ff, best_ff, best_in;
   logic [AW-1:0]        first_ff;
   logic [CW-1:0]        count_ff;
   logic                 have_ff, have_in;
   logic [TagWidth-1:0]  tag_ff, tag_in;
   logic [POS_WIDTH-1:0] nstart_ff, nstart_in;

   logic                 ov_ff;
   logic [1:0]           ostat_ff;
   logic                 ofound_ff;
   logic [TagWidth-1:0]  otag_ff;
   logic [POS_WIDTH-1:0] ostart_ff, odist_ff;

   logic [CW-1:0]        mid;
   logic [POS_WIDTH-1:0] rs, re, gap;
   logic [TagWidth-1:0]  rt;
   logic                 out_free;
   logic                 pass;
   logic                 start_q;
   logic [JW-1:0]        jlo;
   logic                 jok;

   assign {rs, re, rt} = rd_data;
   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign out_free = !ov_ff || !out_stall;
   assign pass     = (state_ff == BK_IDLE) && cmd_valid && !cmd_query && out_free;
   assign start_q  = (state_ff == BK_IDLE) && cmd_valid && cmd_query;
   assign jok      = !j_ff[JW-1] && (j_ff[CW-1:0] < count_ff);
   assign idle     = (state_ff == BK_IDLE);

   // Distance from the query position to the entry just read.
   always_comb begin
      if (pos_ff >= rs && pos_ff <= re) begin
         gap = '0;
      end else if (pos_ff > re) begin
         gap = pos_ff - re;
      end else begin
         gap = rs - pos_ff;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:       if (start_q) state_in = BK_SEARCH_RD;
         BK_SEARCH_RD:  state_in = (lo_ff < hi_ff) ? BK_SEARCH_CMP : BK_SCAN_RD;
         BK_SEARCH_CMP: state_in = BK_SEARCH_RD;
         BK_SCAN_RD: begin
            if ($signed(j_ff) > $signed(jend_ff)) begin
               state_in = BK_DONE;
            end else if (jok) begin
               state_in = BK_SCAN_CMP;
            end
         end
         BK_SCAN_CMP:   state_in = BK_SCAN_RD;
         BK_DONE:       if (out_free) state_in = BK_IDLE;
         default:       state_in = BK_IDLE;
      endcase
   end

   // Datapath updates per state.
   always_comb begin
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      j_in      = j_ff;
      jend_in   = jend_ff;
      best_in   = best_ff;
      have_in   = have_ff;
      tag_in    = tag_ff;
      nstart_in = nstart_ff;
      jlo       = JW'(lo_ff) - JW'(radius);
      rd_addr   = first_ff + mid[AW-1:0];
      case (state_ff)
         BK_IDLE: begin
            lo_in   = '0;
            hi_in   = cmd_count;
            have_in = 1'b0;
         end
         BK_SEARCH_RD: begin
            j_in    = jlo;
            jend_in = JW'(lo_ff) + JW'(radius);
         end
         BK_SEARCH_CMP: begin
            if (rs < pos_ff) begin
               lo_in = mid + CW'(1);
            end else begin
               hi_in = mid;
            end
         end
         BK_SCAN_RD: begin
            rd_addr = first_ff + j_ff[AW-1:0];
            if (!jok) begin
               j_in = j_ff + JW'(1);
            end
         end
         BK_SCAN_CMP: begin
            if (!have_ff || gap < best_ff) begin
               have_in   = 1'b1;
               best_in   = gap;
               tag_in    = rt;
               nstart_in = rs;
            end
            j_in = j_ff + JW'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      j_ff      <= j_in;
      jend_ff   <= jend_in;
      best_ff   <= best_in;
      have_ff   <= have_in;
      tag_ff    <= tag_in;
      nstart_ff <= nstart_in;
      if (start_q) begin
         pos_ff   <= cmd_pos;
         first_ff <= cmd_first;
         count_ff <= cmd_count;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (pass || (state_ff == BK_DONE && out_free)) begin
         ov_ff <= 1'b1;
      end else if (!out_stall) begin
         ov_ff <= 1'b0;
      end
      if (pass) begin
         ostat_ff  <= cmd_status;
         ofound_ff <= 1'b0;
         otag_ff   <= '0;
         ostart_ff <= '0;
         odist_ff  <= '0;
      end else if (state_ff == BK_DONE && out_free) begin
         ostat_ff  <= ST_OK;
         ofound_ff <= have_ff;
         otag_ff   <= have_ff ? tag_ff : '0;
         ostart_ff <= have_ff ? nstart_ff : '0;
         odist_ff  <= have_ff ? best_ff : '0;
      end
   end

   assign cmd_pop    = pass || start_q;
   assign out_valid  = ov_ff;
   assign out_status = ostat_ff;
   assign out_found  = ofound_ff;
   assign out_tag    = otag_ff;
   assign out_start  = ostart_ff;
   assign out_dist   = odist_ff;
endmodule

@@ hdl/nearest_exon_lookup.sv @@
// ----------------------------------------------------------------------------
// nearest_exon_lookup: sorted exon table with nearest-interval query
// Front end checks and stores loads; a two-entry queue feeds a back-end
// sequencer that searches and scans the table for each query.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req_    | in        | req_valid/req_stall | operation chromosome position ...
//  rsp_    | out       | rsp_valid/rsp_stall | status found nearest_tag ...
//  csr_    | in        | csr_wr_en           | csr_wr_data (window radius)
//
// A load, clear or rejected beat passes through the command queue and the output register.
// A query is dispatched from the queue, binary-searches its chromosome's run for the
// landing index, then reads each of the 2*radius+1 window slots that lies inside the run,
// compares it, and finishes once the window is past its end.
// Reset is synchronous and empties the table; no clearing pass is needed.
// A stall on rsp_ backs up to req_stall; a load after a clear waits for drain.
module nearest_exon_lookup #(
   parameter int TABLE_DEPTH     = nel_pkg::DefTableDepth,
   parameter int NUM_CHROMOSOMES = nel_pkg::DefNumChrom,
   parameter int POS_WIDTH       = nel_pkg::DefPosWidth
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_operation,
   input  logic [nel_pkg::ChromWidth-1:0] req_chromosome,
   input  logic [POS_WIDTH-1:0]           req_position,
   input  logic [POS_WIDTH-1:0]           req_interval_end,
   input  logic [nel_pkg::TagWidth-1:0]   req_exon_tag,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic                           rsp_found,
   output logic [nel_pkg::TagWidth-1:0]   rsp_nearest_tag,
   output logic [POS_WIDTH-1:0]           rsp_nearest_start,
   output logic [POS_WIDTH-1:0]           rsp_distance,
   input  logic                           csr_wr_en,
   input  logic [nel_pkg::RadiusWidth-1:0] csr_wr_data
);
   import nel_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = AW + 1;
   localparam int DW = 2 * POS_WIDTH + TagWidth;
   localparam int QW = 1 + 2 + POS_WIDTH + AW + CW;

   logic [RadiusWidth-1:0] radius_ff;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr, rd_addr;
   logic [DW-1:0]          wr_data, rd_data;

   logic            f_valid, f_query;
   logic [1:0]      f_status;
   logic [POS_WIDTH-1:0] f_pos;
   logic [AW-1:0]   f_first;
   logic [CW-1:0]   f_count;
   logic [QW-1:0]   f_word;

   logic [QW-1:0]   q_ff [2];
   logic [QW-1:0]   q_in [2];
   logic [1:0]      qn_ff, qn_in;
   logic            q_pop, q_full;
   logic [QW-1:0]   q_head;
   logic            b_query;
   logic [1:0]      b_status;
   logic [POS_WIDTH-1:0] b_pos;
   logic [AW-1:0]   b_first;
   logic [CW-1:0]   b_count;
   logic            b_idle;
   logic            drained;

   // Window radius register.
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RadiusReset;
      end else if (csr_wr_en) begin
         radius_ff <= csr_wr_data;
      end
   end

   nel_front #(
      .TABLE_DEPTH(TABLE_DEPTH), .NUM_CHROMOSOMES(NUM_CHROMOSOMES), .POS_WIDTH(POS_WIDTH)
   ) u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_stall(req_stall), .in_op(req_operation),
      .in_chrom(req_chromosome), .in_pos(req_position), .in_end(req_interval_end),
      .in_tag(req_exon_tag), .drained,
      .wr_en, .wr_addr, .wr_data,
      .cmd_valid(f_valid), .cmd_stall(q_full), .cmd_query(f_query),
      .cmd_status(f_status), .cmd_pos(f_pos), .cmd_first(f_first), .cmd_count(f_count)
   );

   // Two-entry command queue between front and back.
   assign q_full  = (qn_ff == 2'd2);
   assign q_head  = q_ff[0];
   assign f_word  = {f_query, f_status, f_pos, f_first, f_count};
   assign drained = (qn_ff == 2'd0) && b_idle;

   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      qn_in   = qn_ff + 2'(f_valid) - 2'(q_pop);
      if (q_pop) begin
         q_in[0] = q_ff[1];
      end
      if (f_valid) begin
         if (qn_ff - 2'(q_pop) == 2'd0) begin
            q_in[0] = f_word;
         end else begin
            q_in[1] = f_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qn_ff <= '0;
      end else begin
         qn_ff <= qn_in;
      end
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end
   assign {b_query, b_status, b_pos, b_first, b_count} = q_head;

   nel_ram #(.WIDTH(DW), .DEPTH(TABLE_DEPTH)) u_table (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   nel_back #(.TABLE_DEPTH(TABLE_DEPTH), .POS_WIDTH(POS_WIDTH)) u_back (
      .clock, .reset, .radius(radius_ff),
      .cmd_valid(qn_ff != 2'd0), .cmd_pop(q_pop), .cmd_query(b_query),
      .cmd_status(b_status), .cmd_pos(b_pos), .cmd_first(b_first), .cmd_count(b_count),
      .idle(b_idle),
      .rd_addr, .rd_data,
      .out_valid(rsp_valid), .out_stall(rsp_stall), .out_status(rsp_status),
      .out_found(rsp_found), .out_tag(rsp_nearest_tag), .out_start(rsp_nearest_start),
      .out_dist(rsp_distance)
   );
endmodule

@@ hdl/nel_checker.sv @@
// ----------------------------------------------------------------------------
// nel_checker: port-level checks for the nearest exon lookup
// Watches the response channel and its relation to the result fields.
// ----------------------------------------------------------------------------
module nel_checker #(
   parameter int POS_WIDTH = 28
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [1:0]           rsp_status,
   input logic                 rsp_found,
   input logic [15:0]          rsp_nearest_tag,
   input logic [POS_WIDTH-1:0] rsp_distance
);
   import nel_pkg::*;

   // A stalled beat stays.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_distance))
      else $error("stalled response beat dropped or changed");

   // Only a good query can report a hit.
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == ST_OK)
      else $error("hit reported with error status");

   // A miss carries zero fields.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_distance == '0 && rsp_nearest_tag == '0)
      else $error("miss response with nonzero fields");

   // Nothing comes out in the cycle after reset.
   a_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");
endmodule

bind nearest_exon_lookup nel_checker #(.POS_WIDTH(POS_WIDTH)) u_nel_checker (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_status, .rsp_found,
   .rsp_nearest_tag, .rsp_distance
);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for nearest_exon_lookup
// Loads sorted exon tables, queries nearest exons at several window radii,
// and covers rejected loads, clears, a dense table and output back-pressure.
// Every result is checked against an in-bench predictor of the table.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import nel_pkg::*;

   localparam int Depth    = DefTableDepth;
   localparam int NumChrom = DefNumChrom;
   localparam int PosW     = DefPosWidth;
   localparam int PosMax   = (1 << PosW) - 1;
   localparam int StallLimit = 5000;
   localparam int FillCount  = 120;

   typedef struct packed {
      status_type      status;
      logic            found;
      logic [15:0]     tag;
      logic [PosW-1:0] start;
      logic [PosW-1:0] distance;
   } lookup_result_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [1:0]             req_operation;
   logic [ChromWidth-1:0]  req_chromosome;
   logic [PosW-1:0]        req_position;
   logic [PosW-1:0]        req_interval_end;
   logic [TagWidth-1:0]    req_exon_tag;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [1:0]             rsp_status;
   logic                   rsp_found;
   logic [TagWidth-1:0]    rsp_nearest_tag;
   logic [PosW-1:0]        rsp_nearest_start;
   logic [PosW-1:0]        rsp_distance;
   logic                   csr_wr_en;
   logic [RadiusWidth-1:0] csr_wr_data;

   // Predictor copy of the exon table and its bookkeeping.
   logic [PosW-1:0] exon_start [Depth];
   logic [PosW-1:0] exon_end [Depth];
   logic [15:0]     exon_tag [Depth];
   int              chrom_first [NumChrom];
   int              chrom_count [NumChrom];
   int              table_fill;
   int              last_chrom;
   int              last_start;
   int              radius;

   lookup_result_type expected_q[$];
   int              error_count;
   bit              tx_idle_en;
   bit              rx_idle_en;
   bit              hold_request;
   int              quiet_cycles;

   nearest_exon_lookup dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_chromosome   (req_chromosome),
      .req_position     (req_position),
      .req_interval_end (req_interval_end),
      .req_exon_tag     (req_exon_tag),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_found        (rsp_found),
      .rsp_nearest_tag  (rsp_nearest_tag),
      .rsp_nearest_start(rsp_nearest_start),
      .rsp_distance     (rsp_distance),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void empty_table();
      for (int c = 0; c < NumChrom; c++) begin
         chrom_first[c] = 0;
         chrom_count[c] = 0;
      end
      table_fill = 0;
      last_chrom = 0;
      last_start = 0;
   endfunction

   function automatic logic [PosW-1:0] gap_to(int p, int s, int e);
      if (p >= s && p <= e) return '0;
      if (p > e) return PosW'(p - e);
      return PosW'(s - p);
   endfunction

   // Applies one beat to the predicted table and returns its expected result.
   function automatic lookup_result_type apply_beat(op_type op, int chr, int pos, int iend,
                                                    int tag);
      lookup_result_type r;
      bit              bad;
      bit              have;
      int              c, first, cnt, lo, hi, mid, j;
      logic [PosW-1:0] d;
      logic [PosW-1:0] best;
      r = '0;
      r.status = ST_OK;
      bad = (chr == 0 || chr > NumChrom);
      case (op)
         OP_LOAD: begin
            if (bad) r.status = ST_BADCHROM;
            else if (chr < last_chrom || (chr == last_chrom && pos < last_start))
               r.status = ST_ORDER;
            else if (table_fill >= Depth) r.status = ST_FULL;
            else begin
               c = chr - 1;
               if (chrom_count[c] == 0) chrom_first[c] = table_fill;
               exon_start[table_fill] = PosW'(pos);
               exon_end[table_fill]   = PosW'(iend);
               exon_tag[table_fill]   = 16'(tag);
               chrom_count[c]++;
               table_fill++;
               last_chrom = chr;
               last_start = pos;
            end
         end
         OP_QUERY: begin
            if (bad) r.status = ST_BADCHROM;
            else begin
               c = chr - 1;
               first = chrom_first[c];
               cnt = chrom_count[c];
               lo = 0;
               hi = cnt;
               // Landing index: first entry whose start is at or above pos.
               while (lo < hi) begin
                  mid = lo + (hi - lo) / 2;
                  if (exon_start[first + mid] < pos) lo = mid + 1;
                  else hi = mid;
               end
               have = 0;
               best = '0;
               for (int k = -radius; k <= radius; k++) begin
                  j = lo + k;
                  if (j < 0 || j >= cnt) continue;
                  d = gap_to(pos, exon_start[first + j], exon_end[first + j]);
                  if (!have || d < best) begin
                     have = 1;
                     best = d;
                     r.tag = exon_tag[first + j];
                     r.start = exon_start[first + j];
                  end
               end
               r.found = have;
               r.distance = best;
            end
         end
         OP_CLEAR: empty_table();
         default: ;
      endcase
      return r;
   endfunction

   // Offers one beat and waits until the block takes it.
   task automatic send_beat(op_type op, int chr, int pos, int iend, int tag);
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_chromosome   <= chr[ChromWidth-1:0];
      req_position     <= pos[PosW-1:0];
      req_interval_end <= iend[PosW-1:0];
      req_exon_tag     <= tag[15:0];
      do @(posedge clock); while (req_stall);
      expected_q.insert(expected_q.size(),
                        apply_beat(op, chr[ChromWidth-1:0], pos & PosMax,
                                   iend & PosMax, tag & 16'hFFFF));
      if (tx_idle_en && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // The radius register is only written with the block drained.
   task automatic set_radius(int r);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= r[RadiusWidth-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      radius = r;
   endtask

   task automatic test_directed();
      send_beat(OP_QUERY, 3, 100, 0, 0);
      send_beat(OP_LOAD, 0, 5, 6, 1);
      send_beat(OP_LOAD, 25, 5, 6, 1);
      send_beat(OP_QUERY, 31, 5, 0, 0);
      send_beat(OP_LOAD, 2, 100, 200, 16'h0001);
      send_beat(OP_LOAD, 2, 300, 400, 16'h0002);
      send_beat(OP_LOAD, 2, 300, 250, 16'h0003);
      send_beat(OP_LOAD, 2, 299, 500, 16'h0004);
      send_beat(OP_LOAD, 1, 10, 20, 16'h0005);
      send_beat(OP_LOAD, 24, 0, PosMax, 16'hFFFF);
      send_beat(OP_LOAD, 24, PosMax, PosMax, 16'h8000);
      send_beat(OP_QUERY, 2, 150, 0, 0);
      send_beat(OP_QUERY, 2, 250, 0, 0);
      send_beat(OP_QUERY, 2, 275, 0, 0);
      send_beat(OP_QUERY, 2, 0, 0, 0);
      send_beat(OP_QUERY, 2, PosMax, 0, 0);
      send_beat(OP_QUERY, 24, PosMax, 0, 0);
      send_beat(OP_QUERY, 5, 42, 0, 0);
      send_beat(OP_NONE, 7, 9, 9, 9);
      send_beat(OP_CLEAR, 0, 0, 0, 0);
      send_beat(OP_QUERY, 2, 150, 0, 0);
      send_beat(OP_LOAD, 1, 50, 60, 16'h00AA);
      send_beat(OP_QUERY, 1, 55, 0, 0);
   endtask

   // A clear, a sorted table over a few chromosomes, then queries around it.
   task automatic random_set(int per_chrom, int queries);
      int chr, st, spread, len, n, pick;
      int loaded_chr[$];
      int loaded_pos[$];
      send_beat(OP_CLEAR, 0, 0, 0, 0);
      chr = $urandom_range(1, 4);
      st = $urandom_range(0, 1000);
      spread = ($urandom_range(0, 1) == 0) ? 200 : (1 << 21);
      while (chr <= NumChrom) begin
         n = $urandom_range(0, per_chrom);
         for (int i = 0; i < n; i++) begin
            st += $urandom_range(0, spread);
            if (st > PosMax) st = PosMax;
            len = $urandom_range(0, spread);
            send_beat(OP_LOAD, chr, st,
                      ($urandom_range(0, 9) == 0) ? st - $urandom_range(0, st)
                                                  : ((st + len > PosMax) ? PosMax : st + len),
                      $urandom);
            loaded_chr.insert(loaded_chr.size(), chr);
            loaded_pos.insert(loaded_pos.size(), st);
            if ($urandom_range(0, 19) == 0)
               send_beat(OP_LOAD, $urandom_range(0, 31), $urandom, $urandom, $urandom);
         end
         chr += $urandom_range(1, 8);
         if ($urandom_range(0, 2) == 0) st = $urandom_range(0, 1000);
      end
      for (int q = 0; q < queries; q++) begin
         pick = $urandom_range(0, 9);
         if (pick < 7 && loaded_chr.size() != 0) begin
            n = $urandom_range(0, loaded_chr.size() - 1);
            st = loaded_pos[n] + $urandom_range(0, 2 * spread) - spread;
            if (st < 0) st = 0;
            if (st > PosMax) st = PosMax;
            send_beat(OP_QUERY, loaded_chr[n], st, $urandom, $urandom);
         end else if (pick < 9) begin
            send_beat(OP_QUERY, $urandom_range(0, 31), $urandom, $urandom, $urandom);
         end else begin
            send_beat(op_type'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom,
                      $urandom, $urandom);
         end
      end
   endtask

   task automatic test_radius_sweep();
      int settings[6] = '{0, 15, 8, 1, 12, 5};
      foreach (settings[i]) begin
         set_radius(settings[i]);
         random_set(12, 40);
      end
   endtask

   task automatic test_random_tables();
      for (int s = 0; s < 10; s++) begin
         if (s % 4 == 3) set_radius($urandom_range(0, 15));
         random_set(10, 40);
      end
   endtask

   // Output held off for a long stretch while beats keep coming.
   task automatic test_back_pressure();
      random_set(6, 0);
      hold_request = 1'b1;
      for (int i = 0; i < 30; i++) send_beat(OP_QUERY, $urandom_range(1, 24), $urandom, 0, 0);
      hold_request = 1'b0;
   endtask

   // Packs a dense run over chromosomes 1 to 20, then checks out-of-order rejection
   // at its tail and queries across it.
   task automatic test_dense_table();
      int per;
      set_radius(3);
      send_beat(OP_CLEAR, 0, 0, 0, 0);
      per = FillCount / NumChrom + 1;
      for (int i = 0; i < FillCount; i++)
         send_beat(OP_LOAD, i / per + 1, (i % per) * 1000, (i % per) * 1000 + 400, i);
      send_beat(OP_LOAD, NumChrom, PosMax, PosMax, 1);
      send_beat(OP_LOAD, 1, 0, 0, 1);
      for (int i = 0; i < 20; i++)
         send_beat(OP_QUERY, $urandom_range(1, NumChrom), $urandom_range(0, per * 1000), 0, 0);
      send_beat(OP_CLEAR, 0, 0, 0, 0);
      send_beat(OP_LOAD, 1, 7, 7, 7);
      send_beat(OP_QUERY, 1, 7, 0, 0);
   endtask

   // Result side stall: random bursts, plus a long hold-off on request.
   initial begin
      int burst;
      int hold;
      burst = 0;
      hold = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && hold == 0) hold = 600;
         if (hold > 1) begin
            hold--;
            rsp_stall <= 1'b1;
         end else if (burst > 0) begin
            burst--;
            rsp_stall <= 1'b1;
         end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(0, 15);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
         if (!hold_request && hold == 1) hold = 0;
      end
   end

   // Compares each result beat with the oldest expectation.
   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result beat, actual status %0d", $time, rsp_status);
            error_count++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
               error_count++;
            end
            if (rsp_found !== want.found) begin
               $display("%0t: found expected %0d actual %0d", $time, want.found, rsp_found);
               error_count++;
            end
            if (rsp_nearest_tag !== want.tag) begin
               $display("%0t: nearest_tag expected %h actual %h", $time, want.tag,
                        rsp_nearest_tag);
               error_count++;
            end
            if (rsp_nearest_start !== want.start) begin
               $display("%0t: nearest_start expected %h actual %h", $time, want.start,
                        rsp_nearest_start);
               error_count++;
            end
            if (rsp_distance !== want.distance) begin
               $display("%0t: distance expected %h actual %h", $time, want.distance,
                        rsp_distance);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no beat moving on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > StallLimit) begin
         $display("nearest_exon_lookup: mismatch");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_NONE;
      req_chromosome = '0;
      req_position = '0;
      req_interval_end = '0;
      req_exon_tag = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      hold_request = 1'b0;
      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
      radius = RadiusReset;
      empty_table();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_radius_sweep();
      test_random_tables();
      test_back_pressure();
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b0;
      test_dense_table();

      drain();
      repeat (50) @(posedge clock);
      if (error_count == 0 && expected_q.size() == 0)
         $display("nearest_exon_lookup: match");
      else
         $display("nearest_exon_lookup: mismatch");
      $finish;
   end

endmodule

@@ nearest_exon_lookup.f @@
hdl/nel_pkg.sv
hdl/nel_ram.sv
hdl/nel_front.sv
hdl/nel_back.sv
hdl/nearest_exon_lookup.sv
hdl/nel_checker.sv
tb/testbench.sv
